// ===== rtl/mtq_pkg.sv =====
package mtq_pkg;

    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 32;
    localparam int FIELD_BITS = 32;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int COUNT_BITS = 11;
    localparam int OP_BITS    = 2;

    localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POP  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PEEK = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [OP_BITS-1:0]           opcode;
        logic signed [FIELD_BITS-1:0] new_key;
        logic signed [FIELD_BITS-1:0] new_tag;
    } req_item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] front_key;
        logic signed [FIELD_BITS-1:0] front_tag;
        logic signed [FIELD_BITS-1:0] max_key;
        logic signed [FIELD_BITS-1:0] max_tag;
        logic [COUNT_BITS-1:0]        item_count;
        logic                         is_empty;
        logic                         op_error;
    } rsp_item_t;

    typedef struct packed {
        value_t key;
        value_t tag;
    } pair_t;

    typedef struct packed {
        pair_t item;
        pair_t peak;
    } entry_t;

    typedef struct packed {
        logic push;
        logic xfer_rd;
        logic xfer_wr;
        logic pop;
        logic refill;
        logic load;
        logic err;
    } dp_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic out_zero;
        logic empty;
        logic full;
    } dp_stat_t;

    localparam value_t LOW_VALUE = {1'b1, {(VALUE_BITS-1){1'b0}}};

    function automatic logic above(pair_t a, pair_t b);
        return (a.key > b.key) || ((a.key == b.key) && (a.tag > b.tag));
    endfunction

endpackage

// ===== rtl/mtq_ram.sv =====
module mtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mtq_ctrl.sv =====
module mtq_ctrl
    import mtq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [OP_BITS-1:0] opcode,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  dp_stat_t           stat,
    output dp_cmd_t            cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFER_RD,
        ST_XFER_WR,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    logic   pop_reg, pop_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   rsp_free;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        pop_next       = pop_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        cmd.err        = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DONE;
                    err_next   = 1'b0;
                    pop_next   = (opcode == OP_POP);
                    priority if (opcode == OP_PUSH)
                    begin
                        if (stat.full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (opcode == OP_POP || opcode == OP_PEEK)
                    begin
                        priority if (stat.empty)
                        begin
                            err_next = 1'b1;
                        end
                        else if (stat.out_zero)
                        begin
                            state_next = ST_XFER_RD;
                        end
                        else if (opcode == OP_POP)
                        begin
                            state_next = ST_POP_RD;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            ST_XFER_RD:
            begin
                cmd.xfer_rd = 1'b1;
                state_next  = ST_XFER_WR;
            end
            ST_XFER_WR:
            begin
                cmd.xfer_wr = 1'b1;
                priority if (!stat.in_zero)
                begin
                    state_next = ST_XFER_RD;
                end
                else if (pop_reg)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                cmd.refill = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    cmd.load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            err_reg       <= 1'b0;
            pop_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            pop_reg       <= pop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("accepted item did not leave idle");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> rsp_free)
        else $error("result loaded over a waiting result");

    a_pop_not_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_RD) |-> (!err_reg && pop_reg))
        else $error("pop issued for a refused or non-pop item");

endmodule

// ===== rtl/mtq_datapath.sv =====
module mtq_datapath
    import mtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output rsp_item_t rsp
);

    logic [CNT_BITS-1:0] in_depth_reg, in_depth_next;
    logic [CNT_BITS-1:0] out_depth_reg, out_depth_next;
    logic [CNT_BITS-1:0] total;
    logic [CNT_BITS-1:0] in_dec;
    logic [CNT_BITS-1:0] out_dec2;
    pair_t               in_max_reg;
    pair_t               in_bot_reg;
    entry_t              out_top_reg;
    rsp_item_t           rsp_reg;
    pair_t               new_pair;
    entry_t              push_entry;
    entry_t              in_rdata;
    entry_t              out_rdata;
    entry_t              xfer_entry;
    pair_t               front;
    pair_t               peak;
    logic                in_have;
    logic                out_have;

    assign total    = in_depth_reg + out_depth_reg;
    assign in_dec   = in_depth_reg - CNT_BITS'(1);
    assign out_dec2 = out_depth_reg - CNT_BITS'(2);
    assign in_have  = (in_depth_reg != '0);
    assign out_have = (out_depth_reg != '0);

    assign stat.in_zero  = !in_have;
    assign stat.out_zero = !out_have;
    assign stat.empty    = (total == '0);
    assign stat.full     = (total >= CNT_BITS'(DEPTH));

    assign new_pair.key = value_t'(req.new_key[VALUE_BITS-1:0]);
    assign new_pair.tag = value_t'(req.new_tag[VALUE_BITS-1:0]);

    always_comb
    begin
        push_entry.item = new_pair;
        push_entry.peak = (in_have && above(in_max_reg, new_pair)) ? in_max_reg : new_pair;
        xfer_entry.item = in_rdata.item;
        xfer_entry.peak = (out_have && above(out_top_reg.peak, in_rdata.item))
                        ? out_top_reg.peak : in_rdata.item;
    end

    mtq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(DEPTH)
    ) u_intake_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (in_depth_reg[ADDR_BITS-1:0]),
        .wdata (push_entry),
        .re    (cmd.xfer_rd),
        .raddr (in_dec[ADDR_BITS-1:0]),
        .rdata (in_rdata)
    );

    mtq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(DEPTH)
    ) u_outlet_ram (
        .clk   (clk),
        .we    (cmd.xfer_wr),
        .waddr (out_depth_reg[ADDR_BITS-1:0]),
        .wdata (xfer_entry),
        .re    (cmd.pop),
        .raddr (out_dec2[ADDR_BITS-1:0]),
        .rdata (out_rdata)
    );

    always_comb
    begin
        in_depth_next  = in_depth_reg;
        out_depth_next = out_depth_reg;
        if (cmd.push)
        begin
            in_depth_next = in_depth_reg + CNT_BITS'(1);
        end
        if (cmd.xfer_rd)
        begin
            in_depth_next = in_dec;
        end
        if (cmd.xfer_wr)
        begin
            out_depth_next = out_depth_reg + CNT_BITS'(1);
        end
        if (cmd.pop)
        begin
            out_depth_next = out_depth_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_depth_reg  <= '0;
            out_depth_reg <= '0;
        end
        else
        begin
            in_depth_reg  <= in_depth_next;
            out_depth_reg <= out_depth_next;
        end
    end

    always_comb
    begin
        front.key = LOW_VALUE;
        front.tag = LOW_VALUE;
        peak.key  = LOW_VALUE;
        peak.tag  = LOW_VALUE;
        priority if (out_have)
        begin
            front = out_top_reg.item;
        end
        else if (in_have)
        begin
            front = in_bot_reg;
        end
        if (in_have)
        begin
            peak = in_max_reg;
        end
        if (out_have && above(out_top_reg.peak, peak))
        begin
            peak = out_top_reg.peak;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            in_max_reg <= push_entry.peak;
            if (!in_have)
            begin
                in_bot_reg <= new_pair;
            end
        end
        if (cmd.xfer_wr)
        begin
            out_top_reg <= xfer_entry;
        end
        if (cmd.refill)
        begin
            out_top_reg <= out_rdata;
        end
        if (cmd.load)
        begin
            rsp_reg.front_key  <= FIELD_BITS'(front.key);
            rsp_reg.front_tag  <= FIELD_BITS'(front.tag);
            rsp_reg.max_key    <= FIELD_BITS'(peak.key);
            rsp_reg.max_tag    <= FIELD_BITS'(peak.tag);
            rsp_reg.item_count <= COUNT_BITS'(total);
            rsp_reg.is_empty   <= (total == '0);
            rsp_reg.op_error   <= cmd.err;
        end
    end

    assign rsp = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= CNT_BITS'(DEPTH))
        else $error("queue holds more pairs than its depth");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push issued on a full queue");

    a_xfer_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.xfer_rd |-> in_have)
        else $error("move started with an empty intake stack");

    a_pop_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> out_have)
        else $error("pop issued on an empty outlet stack");

endmodule

// ===== rtl/max_tracking_fifo_queue.sv =====
// Channel   Handshake             Payload   Moves
// request   req_valid/req_stall   req_item  one push, pop or peek per transfer
// response  rsp_valid/rsp_stall   rsp_item  one result per request
//
// Push, and peek on a non-empty outlet stack, go from idle straight to done; pop first
// passes the pop-read and pop-wait states. A pop or peek on a non-empty queue with an
// empty outlet stack first moves the intake stack across pair by pair, read then write.
// rst_n clears both stack depths and the response valid; stack memories are not cleared.
// req_stall is high while an item is in work; a stalled response holds the next result.
module max_tracking_fifo_queue
    import mtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (req_item.opcode),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_item),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp_item)
    );

endmodule
